// ===== design/ilha_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ilha_pkg
// Shared types, constants and the reset image of the heap.
// ---------------------------------------------------------------------------
package ilha_pkg;

  localparam int HEAP_BYTES_DEF = 16384;
  localparam int ADDR_W         = 14;
  localparam int REQ_W          = 15;
  localparam int STATUS_W       = 2;
  localparam int WORD_W         = 32;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0]   payload_addr;
    logic [STATUS_W-1:0] status;
  } res_t;

  // reset value of heap word idx: pad, prologue, one free block, epilogue
  function automatic logic [WORD_W-1:0] init_word(input int idx, input int hb);
    int last;
    logic [WORD_W-1:0] w;
    last = hb >> 2;
    w = '0;
    if (idx == 1 || idx == 2) begin
      w = WORD_W'(9);
    end else if (idx == 3 || idx == last - 2) begin
      w = WORD_W'(hb - 16);
    end else if (idx == last - 1) begin
      w = WORD_W'(1);
    end
    return w;
  endfunction

endpackage

// ===== design/ilha_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ilha_ram
// Generic single-port synchronous RAM, registered read.
// ---------------------------------------------------------------------------
module ilha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/ilha_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ilha_ctrl
// Sequencer: heap clear, first-fit walk with split, free with coalescing.
// ---------------------------------------------------------------------------
module ilha_ctrl #(
  parameter int HEAP_BYTES = ilha_pkg::HEAP_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               mode,
  input  logic [ilha_pkg::REQ_W-1:0]         request_bytes,
  input  logic [ilha_pkg::ADDR_W-1:0]        block_addr,
  output logic                               res_valid,
  input  logic                               res_ready,
  output ilha_pkg::res_t                     res,
  output logic                               ram_we,
  output logic [$clog2(HEAP_BYTES/4)-1:0]    ram_addr,
  output logic [ilha_pkg::WORD_W-1:0]        ram_wdata,
  input  logic [ilha_pkg::WORD_W-1:0]        ram_rdata
);
  import ilha_pkg::*;

  localparam int HW  = HEAP_BYTES / 4;
  localparam int WA  = $clog2(HW);
  localparam int BW  = WORD_W;
  localparam logic [BW-1:0] HB    = BW'(HEAP_BYTES);
  localparam logic [BW-1:0] FIRST = BW'(12);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_A_RD, S_A_CHK, S_A_W1, S_A_W2, S_A_W3, S_A_W4,
    S_F_RD, S_F_CHK, S_F_W1, S_F_W2, S_F_PF_RD, S_F_PF, S_F_PH_RD, S_F_PH,
    S_F_NH_RD, S_F_NH, S_F_M1, S_F_M2,
    S_DONE
  } state_t;

  state_t          state;
  logic [WA-1:0]   clr_idx;
  logic [BW-1:0]   h, size, need, psize, nsize;
  logic            prev_free, next_free;
  res_t            res_q;

  logic [BW-1:0]   rd_size, need_next, h_walk, nh, total, baddr;
  logic [16:0]     need_raw;
  logic            rd_alloc, split;

  assign rd_size   = {ram_rdata[BW-1:3], 3'b000};
  assign rd_alloc  = ram_rdata[0];
  assign need_raw  = {2'b00, request_bytes} + 17'd23;
  assign need_next = BW'({need_raw[16:3], 3'b000});
  assign h_walk    = h + rd_size;
  assign nh        = h + size;
  assign split     = (size - need) > BW'(8);
  assign total     = (prev_free ? psize : '0) + size + (next_free ? nsize : '0);

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = res_q;

  always_comb begin
    logic [BW-1:0] wval;
    logic          wr;
    baddr = h;
    wval  = '0;
    wr    = 1'b0;
    case (state)
      S_A_W1: begin
        wr = 1'b1;
        wval = (split ? need : size) | BW'(1);
      end
      S_A_W2: begin
        wr = 1'b1;
        baddr = h + (split ? need : size) - BW'(4);
        wval = (split ? need : size) | BW'(1);
      end
      S_A_W3: begin
        wr = 1'b1;
        baddr = h + need;
        wval = size - need;
      end
      S_A_W4: begin
        wr = 1'b1;
        baddr = h + size - BW'(4);
        wval = size - need;
      end
      S_F_W1: begin
        wr = 1'b1;
        wval = size;
      end
      S_F_W2: begin
        wr = 1'b1;
        baddr = h + size - BW'(4);
        wval = size;
      end
      S_F_PF_RD: baddr = h - BW'(4);
      S_F_PH_RD: baddr = h - psize;
      S_F_NH_RD: baddr = nh;
      S_F_M1: begin
        wr = 1'b1;
        baddr = prev_free ? (h - psize) : h;
        wval = total;
      end
      S_F_M2: begin
        wr = 1'b1;
        baddr = next_free ? (nh + nsize - BW'(4)) : (h + size - BW'(4));
        wval = total;
      end
      default: baddr = h;
    endcase
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_idx;
      ram_wdata = init_word(int'(clr_idx), HEAP_BYTES);
    end else begin
      ram_we    = wr && (baddr < HB);
      ram_addr  = baddr[WA+1:2];
      ram_wdata = WORD_W'(wval);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + WA'(1);
          if (clr_idx == WA'(HW - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            res_q.payload_addr <= '0;
            if (mode == MODE_ALLOC) begin
              need <= need_next;
              h    <= FIRST;
              if (request_bytes == '0) begin
                res_q.status <= ST_ZERO;
                state        <= S_DONE;
              end else begin
                res_q.status <= ST_OK;
                state        <= S_A_RD;
              end
            end else begin
              res_q.status <= ST_OK;
              h <= BW'(block_addr) - BW'(4);
              if (block_addr[2:0] != 3'd0 || block_addr < ADDR_W'(16) ||
                  (BW'(block_addr) - BW'(4)) >= HB) begin
                state <= S_DONE;
              end else begin
                state <= S_F_RD;
              end
            end
          end
        end
        S_A_RD: state <= S_A_CHK;
        S_A_CHK: begin
          if (rd_size == '0) begin
            res_q.status <= ST_FULL;
            state        <= S_DONE;
          end else if (!rd_alloc && rd_size >= need) begin
            size               <= rd_size;
            res_q.payload_addr <= ADDR_W'(h + BW'(4));
            state              <= S_A_W1;
          end else if (h_walk > HB - BW'(4)) begin
            res_q.status <= ST_FULL;
            state        <= S_DONE;
          end else begin
            h     <= h_walk;
            state <= S_A_RD;
          end
        end
        S_A_W1: state <= S_A_W2;
        S_A_W2: state <= split ? S_A_W3 : S_DONE;
        S_A_W3: state <= S_A_W4;
        S_A_W4: state <= S_DONE;
        S_F_RD: state <= S_F_CHK;
        S_F_CHK: begin
          size <= rd_size;
          if (!rd_alloc || rd_size == '0 || rd_size > HB - BW'(4) - h) begin
            state <= S_DONE;
          end else begin
            state <= S_F_W1;
          end
        end
        S_F_W1: state <= S_F_W2;
        S_F_W2: state <= S_F_PF_RD;
        S_F_PF_RD: state <= S_F_PF;
        S_F_PF: begin
          psize     <= rd_size;
          prev_free <= 1'b0;
          if (!rd_alloc && rd_size != '0 && rd_size <= h - FIRST) begin
            state <= S_F_PH_RD;
          end else begin
            state <= S_F_NH_RD;
          end
        end
        S_F_PH_RD: state <= S_F_PH;
        S_F_PH: begin
          prev_free <= !rd_alloc;
          state     <= S_F_NH_RD;
        end
        S_F_NH_RD: state <= S_F_NH;
        S_F_NH: begin
          nsize     <= rd_size;
          next_free <= !rd_alloc && rd_size != '0;
          if (prev_free || (!rd_alloc && rd_size != '0)) begin
            state <= S_F_M1;
          end else begin
            state <= S_DONE;
          end
        end
        S_F_M1: state <= S_F_M2;
        S_F_M2: state <= S_DONE;
        S_DONE: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !ram_we)
    else $error("heap written while idle");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ST_OK |-> res.payload_addr == '0)
    else $error("nonzero address on failed request");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> state == S_CLEAR)
    else $error("reset did not start heap clear");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while waiting");

endmodule

// ===== design/implicit_list_heap_allocator_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// implicit_list_heap_allocator_unit
// First-fit implicit free-list heap allocator over one synchronous RAM.
// ---------------------------------------------------------------------------
// After reset the heap RAM is initialized one word per cycle, with in_stall
// high. An allocate reads and checks block headers one after another until
// a free block fits, then writes its header and footer, and those of the
// remainder when the found block is split; a zero request or a misaligned
// free ends at once, a free rejected on its header after reading it, and a
// valid free writes the freed header and footer, reads the neighbors and
// merges with any that are free. One item is in work at a time; the result
// sits in an output register so the next item can enter meanwhile.
module implicit_list_heap_allocator_unit #(
  parameter int HEAP_BYTES = ilha_pkg::HEAP_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [ilha_pkg::REQ_W-1:0]    request_bytes,
  input  logic [ilha_pkg::ADDR_W-1:0]   block_addr,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ilha_pkg::ADDR_W-1:0]   payload_addr,
  output logic [ilha_pkg::STATUS_W-1:0] status
);
  import ilha_pkg::*;

  localparam int HW = HEAP_BYTES / 4;
  localparam int WA = $clog2(HW);

  logic              res_valid, res_ready, ram_we;
  res_t              res;
  logic [WA-1:0]     ram_addr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  assign res_ready = !out_valid || !out_stall;

  ilha_ctrl #(.HEAP_BYTES(HEAP_BYTES)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .mode, .request_bytes, .block_addr,
    .res_valid, .res_ready, .res, .ram_we, .ram_addr, .ram_wdata, .ram_rdata
  );

  ilha_ram #(.WIDTH(WORD_W), .DEPTH(HW)) u_ram (
    .clk, .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid    <= 1'b1;
      payload_addr <= res.payload_addr;
      status       <= res.status;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== bench/implicit_list_heap_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// implicit_list_heap_allocator_unit_tb
// Drives allocate and free requests into the heap allocator and checks every
// transfer on the result side against a first-fit heap predictor. A directed
// table opens the run, then random phases with varied idling and back-pressure.
// ---------------------------------------------------------------------------
module implicit_list_heap_allocator_unit_tb;
  import ilha_pkg::*;

  localparam int HB     = HEAP_BYTES_DEF;
  localparam int HWORDS = HB / 4;
  localparam int NRAND  = 1330;

  typedef struct {
    logic             md;
    logic [REQ_W-1:0] req;
    logic [ADDR_W-1:0] addr;
    bit               has_exp;
    logic [ADDR_W-1:0] exp_addr;
    logic [STATUS_W-1:0] exp_status;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = MODE_ALLOC;
  logic [REQ_W-1:0] request_bytes = '0;
  logic [ADDR_W-1:0] block_addr = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ADDR_W-1:0] payload_addr;
  logic [STATUS_W-1:0] status;

  implicit_list_heap_allocator_unit #(.HEAP_BYTES(HB)) DUT (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  logic [31:0] model_heap [HWORDS];
  res_t pending_results[$];
  logic [ADDR_W-1:0] live_blocks[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 1'b0;

  function automatic logic [31:0] hrd(logic [31:0] a);
    if ((a >> 2) >= HWORDS) return 32'h1;
    return model_heap[a >> 2];
  endfunction

  function automatic void hwr(logic [31:0] a, logic [31:0] v);
    if ((a >> 2) < HWORDS) model_heap[a >> 2] = v;
  endfunction

  function automatic void hmark(logic [31:0] h, logic [31:0] sz, logic [31:0] al);
    hwr(h, sz | al);
    hwr(h + sz - 4, sz | al);
  endfunction

  function automatic void heap_reset();
    for (int i = 0; i < HWORDS; i++) model_heap[i] = '0;
    hwr(4, 9);
    hwr(8, 9);
    hmark(12, HB - 16, 0);
    hwr(HB - 4, 1);
  endfunction

  function automatic res_t heap_alloc(logic [31:0] req);
    res_t r;
    logic [31:0] need, h, w, sz, rest;
    r.payload_addr = '0;
    r.status = ST_FULL;
    if (req == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    need = (req + 23) & 32'hFFFF_FFF8;
    h = 12;
    forever begin
      w = hrd(h);
      sz = w & 32'hFFFF_FFF8;
      if (sz == 0) break;
      if (!w[0] && sz >= need) begin
        rest = sz - need;
        if (rest > 8) begin
          hmark(h, need, 1);
          hmark(h + need, rest, 0);
        end else begin
          hmark(h, sz, 1);
        end
        r.status = ST_OK;
        r.payload_addr = ADDR_W'(h + 4);
        return r;
      end
      h += sz;
      if (h > HB - 4) break;
    end
    return r;
  endfunction

  function automatic void heap_free(logic [31:0] p);
    logic [31:0] h, w, sz, pf, psz, ph, pw, nh, nw, nsz;
    bit pfree, nfree;
    pfree = 0;
    ph = 0;
    psz = 0;
    if (p[2:0] != 0 || p < 16) return;
    h = p - 4;
    w = hrd(h);
    sz = w & 32'hFFFF_FFF8;
    if (!w[0] || sz == 0) return;
    if (sz > HB - 4 - h) return;
    hmark(h, sz, 0);
    pf = hrd(h - 4);
    psz = pf & 32'hFFFF_FFF8;
    if (!pf[0] && psz != 0 && psz <= h - 12) begin
      ph = h - psz;
      pw = hrd(ph);
      pfree = !pw[0];
    end
    nh = h + sz;
    nw = hrd(nh);
    nsz = nw & 32'hFFFF_FFF8;
    nfree = !nw[0] && nsz != 0;
    if (pfree && nfree) begin
      hwr(ph, psz + sz + nsz);
      hwr(nh + nsz - 4, psz + sz + nsz);
    end else if (pfree) begin
      hwr(ph, psz + sz);
      hwr(h + sz - 4, psz + sz);
    end else if (nfree) begin
      hwr(h, sz + nsz);
      hwr(nh + nsz - 4, sz + nsz);
    end
  endfunction

  function automatic res_t predict_transfer(logic md, logic [REQ_W-1:0] req,
                                            logic [ADDR_W-1:0] addr);
    res_t r;
    r.payload_addr = '0;
    r.status = ST_OK;
    if (md == MODE_ALLOC) begin
      r = heap_alloc(32'(req));
      if (r.status == ST_OK) live_blocks.push_back(r.payload_addr);
    end else begin
      heap_free(32'(addr));
    end
    return r;
  endfunction

  task automatic send_item(logic md, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] addr,
                           bit has_exp, logic [ADDR_W-1:0] ea, logic [STATUS_W-1:0] es);
    res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= md;
    request_bytes <= req;
    block_addr <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_transfer(md, req, addr);
    if (has_exp && (r.payload_addr !== ea || r.status !== es)) begin
      $error("directed row disagrees: payload_addr exp %0d got %0d, status exp %0d got %0d",
             ea, r.payload_addr, es, r.status);
      errors++;
    end
    pending_results.push_back(r);
  endtask

  task automatic send_random();
    int k;
    logic [ADDR_W-1:0] a;
    logic [REQ_W-1:0] q;
    k = $urandom_range(99);
    if (k < 50) begin
      case ($urandom_range(9))
        0: q = REQ_W'($urandom_range(16384));
        1: q = REQ_W'($urandom);
        2: q = 0;
        default: q = REQ_W'($urandom_range(1, 300));
      endcase
      send_item(MODE_ALLOC, q, ADDR_W'($urandom), 0, '0, '0);
    end else if (k < 88 && live_blocks.size() > 0) begin
      k = $urandom_range(live_blocks.size() - 1);
      a = live_blocks[k];
      live_blocks.delete(k);
      send_item(MODE_FREE, REQ_W'($urandom), a, 0, '0, '0);
    end else begin
      send_item(MODE_FREE, REQ_W'($urandom), ADDR_W'($urandom), 0, '0, '0);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  // result side: stall driving and checking
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer: payload_addr %0d status %0d",
                 payload_addr, status);
          errors++;
        end else begin
          res_t e;
          e = pending_results.pop_front();
          if (payload_addr !== e.payload_addr) begin
            $error("payload_addr: expected %0d, actual %0d", e.payload_addr, payload_addr);
            errors++;
          end
          if (status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, status);
            errors++;
          end
        end
      end
      out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
    end
  end

  row_t dir_rows[] = '{
    '{MODE_ALLOC, 15'd0,     14'd0,  1, 14'd0,  ST_ZERO},
    '{MODE_ALLOC, 15'd16384, 14'd0,  1, 14'd0,  ST_FULL},
    '{MODE_ALLOC, 15'h7FFF,  14'd0,  1, 14'd0,  ST_FULL},
    '{MODE_ALLOC, 15'd1,     14'd0,  1, 14'd16, ST_OK},
    '{MODE_ALLOC, 15'd8,     14'd0,  1, 14'd40, ST_OK},
    '{MODE_ALLOC, 15'd100,   14'd0,  0, 14'd0,  ST_OK},
    '{MODE_ALLOC, 15'd40,    14'd0,  0, 14'd0,  ST_OK},
    '{MODE_FREE,  15'd0,     14'd40, 1, 14'd0,  ST_OK},
    '{MODE_FREE,  15'd0,     14'd40, 1, 14'd0,  ST_OK},
    '{MODE_FREE,  15'd0,     14'd0,  1, 14'd0,  ST_OK},
    '{MODE_FREE,  15'd0,     14'd8,  1, 14'd0,  ST_OK},
    '{MODE_FREE,  15'd0,     14'd17, 1, 14'd0,  ST_OK},
    '{MODE_FREE,  15'd0,     14'h3FFF, 1, 14'd0, ST_OK},
    '{MODE_FREE,  15'd0,     14'h3FF8, 1, 14'd0, ST_OK},
    '{MODE_FREE,  15'd0,     14'd16, 1, 14'd0,  ST_OK},
    '{MODE_FREE,  15'h7FFF,  14'd64, 0, 14'd0,  ST_OK},
    '{MODE_ALLOC, 15'd16,    14'd0,  0, 14'd0,  ST_OK},
    '{MODE_ALLOC, 15'd1,     14'd0,  0, 14'd0,  ST_OK},
    '{MODE_ALLOC, 15'd16360, 14'd0,  0, 14'd0,  ST_OK},
    '{MODE_ALLOC, 15'd8,     14'd0,  0, 14'd0,  ST_OK},
    '{MODE_FREE,  15'd0,     14'd16, 0, 14'd0,  ST_OK},
    '{MODE_FREE,  15'd0,     14'd64, 0, 14'd0,  ST_OK},
    '{MODE_ALLOC, 15'd16344, 14'd0,  0, 14'd0,  ST_OK}
  };

  initial begin
    heap_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i])
      send_item(dir_rows[i].md, dir_rows[i].req, dir_rows[i].addr, dir_rows[i].has_exp,
                dir_rows[i].exp_addr, dir_rows[i].exp_status);
    drain();
    // long receiver hold-off while the sender keeps offering
    hold_recv = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_recv = 1'b0;
      end
      repeat (20) send_random();
    join
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 80 : ((ph == 3) ? 20 : 0);
      recv_stall_pct = (ph == 2) ? 80 : ((ph == 3) ? 20 : 0);
      for (int n = 0; n < (NRAND - 20) / 4; n++) send_random();
      drain();
    end
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(200_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
design/ilha_pkg.sv
design/ilha_ram.sv
design/ilha_ctrl.sv
design/implicit_list_heap_allocator_unit.sv
bench/implicit_list_heap_allocator_unit_tb.sv
